FILE: rtl/ctts_pkg.sv
// Shared types and constants of the cyclic task tick scheduler.
package ctts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int TIME_W = 32;
  localparam int OVR_W = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] RUN_LIMIT = 32'd1000000;
  localparam logic [OVR_W-1:0] OVR_MAX = {OVR_W{1'b1}};

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_REGISTER = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STOP = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_OVERRUN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [TIME_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic strobe;
    logic [3:0] task_index;
    logic fired;
    logic [1:0] status;
    logic fault_raised;
    logic [OVR_W-1:0] overrun_count;
    logic [TIME_W-1:0] tick_count;
    logic last_result;
  } result_t;

endpackage

FILE: rtl/ctts_front.sv
// Front end: accepts command words, folds the operand, and queues them for the back end.
module ctts_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind,
  input  logic [ctts_pkg::TIME_W-1:0] current_time,
  input  logic [ctts_pkg::TIME_W-1:0] interval,
  output logic cmd_valid,
  output ctts_pkg::cmd_t cmd,
  input  logic cmd_pop
);

  ctts_pkg::cmd_t queue [ctts_pkg::QUEUE_DEPTH];
  logic head;
  logic tail;
  logic [1:0] count;
  logic push;
  ctts_pkg::cmd_t word;

  always_comb begin
    word.kind = kind;
    word.operand = (kind == ctts_pkg::KIND_TICK) ? current_time : interval;
  end

  assign busy = (count == 2'(ctts_pkg::QUEUE_DEPTH));
  assign push = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd = queue[head];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (cmd_pop) begin
        head <= ~head;
      end
      case ({push, cmd_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/ctts_back.sv
// Back end: task table, tick bookkeeping and the slot walk that reports firings.
module ctts_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  ctts_pkg::cmd_t cmd,
  output logic cmd_pop,
  output ctts_pkg::result_t res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [ctts_pkg::TIME_W-1:0] interval_tab [ctts_pkg::TASK_SLOTS];
  logic [ctts_pkg::TIME_W-1:0] remaining_tab [ctts_pkg::TASK_SLOTS];
  logic [ctts_pkg::TIME_W-1:0] run_tab [ctts_pkg::TASK_SLOTS];

  logic [1:0] state;
  logic [ctts_pkg::CNT_W-1:0] used_slots;
  logic [ctts_pkg::TIME_W-1:0] prev_time;
  logic running;
  logic [ctts_pkg::TIME_W-1:0] ticks;
  logic [ctts_pkg::OVR_W-1:0] overruns;
  logic [ctts_pkg::SLOT_W-1:0] walk;
  logic [ctts_pkg::TIME_W-1:0] elapsed;

  logic pend_valid;
  logic [ctts_pkg::SLOT_W-1:0] pend_index;
  logic pend_fault;
  logic [ctts_pkg::OVR_W-1:0] pend_ovr;

  logic [ctts_pkg::TIME_W-1:0] elapsed_now;
  logic [ctts_pkg::TIME_W-1:0] ticks_inc;
  logic [ctts_pkg::OVR_W-1:0] ovr_bump;
  logic [ctts_pkg::TIME_W-1:0] cur_rem;
  logic [ctts_pkg::TIME_W-1:0] run_inc;
  logic fire;
  logic over_lim;
  logic walk_last;
  logic table_full;

  function automatic ctts_pkg::result_t make_res(
    input logic [3:0] idx,
    input logic fired,
    input logic [1:0] status,
    input logic fault,
    input logic [ctts_pkg::OVR_W-1:0] ovr,
    input logic [ctts_pkg::TIME_W-1:0] tcount,
    input logic last
  );
    ctts_pkg::result_t r;
    r.strobe = 1'b1;
    r.task_index = idx;
    r.fired = fired;
    r.status = status;
    r.fault_raised = fault;
    r.overrun_count = ovr;
    r.tick_count = tcount;
    r.last_result = last;
    return r;
  endfunction

  assign cmd_pop = cmd_valid && (state == ST_IDLE);
  assign elapsed_now = cmd.operand - prev_time;
  assign ticks_inc = ticks + 32'd1;
  assign ovr_bump = (overruns == ctts_pkg::OVR_MAX) ? overruns : overruns + 31'd1;
  assign cur_rem = remaining_tab[walk];
  assign run_inc = run_tab[walk] + 32'd1;
  assign fire = (cur_rem <= elapsed);
  assign over_lim = (run_inc > ctts_pkg::RUN_LIMIT);
  assign walk_last = ((ctts_pkg::CNT_W'(walk) + ctts_pkg::CNT_W'(1)) == used_slots);
  assign table_full = (used_slots >= ctts_pkg::CNT_W'(ctts_pkg::TASK_SLOTS));

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_pop && cmd.kind == ctts_pkg::KIND_REGISTER &&
        !table_full) begin
      interval_tab[used_slots[ctts_pkg::SLOT_W-1:0]] <= cmd.operand;
      remaining_tab[used_slots[ctts_pkg::SLOT_W-1:0]] <= '0;
      run_tab[used_slots[ctts_pkg::SLOT_W-1:0]] <= '0;
    end else if (state == ST_WALK) begin
      if (fire) begin
        remaining_tab[walk] <= interval_tab[walk];
        run_tab[walk] <= run_inc;
      end else begin
        remaining_tab[walk] <= cur_rem - elapsed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used_slots <= '0;
      prev_time <= '0;
      running <= 1'b0;
      ticks <= '0;
      overruns <= '0;
      walk <= '0;
      elapsed <= '0;
      pend_valid <= 1'b0;
      pend_index <= '0;
      pend_fault <= 1'b0;
      pend_ovr <= '0;
      res <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              ctts_pkg::KIND_REGISTER: begin
                if (!table_full) begin
                  used_slots <= used_slots + ctts_pkg::CNT_W'(1);
                  res <= make_res(4'(used_slots), 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                  overruns, ticks, 1'b1);
                end else begin
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_FULL, 1'b0,
                                  overruns, ticks, 1'b1);
                end
              end
              ctts_pkg::KIND_START: begin
                if (!running) begin
                  running <= 1'b1;
                  prev_time <= '0;
                  ticks <= '0;
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                  overruns, '0, 1'b1);
                end else begin
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                  overruns, ticks, 1'b1);
                end
              end
              ctts_pkg::KIND_STOP: begin
                running <= 1'b0;
                res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                overruns, ticks, 1'b1);
              end
              default: begin
                ticks <= ticks_inc;
                prev_time <= cmd.operand;
                if (!running) begin
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                  overruns, ticks_inc, 1'b1);
                end else if (elapsed_now[ctts_pkg::TIME_W-1]) begin
                  overruns <= ovr_bump;
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OVERRUN, 1'b0,
                                  ovr_bump, ticks_inc, 1'b1);
                end else if (used_slots == '0) begin
                  res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                                  overruns, ticks_inc, 1'b1);
                end else begin
                  res.strobe <= 1'b0;
                  elapsed <= elapsed_now;
                  walk <= '0;
                  pend_valid <= 1'b0;
                  state <= ST_WALK;
                end
              end
            endcase
          end else begin
            res.strobe <= 1'b0;
          end
        end
        ST_WALK: begin
          if (fire) begin
            if (over_lim) begin
              overruns <= ovr_bump;
            end
            pend_valid <= 1'b1;
            pend_index <= walk;
            pend_fault <= over_lim && walk[0];
            pend_ovr <= over_lim ? ovr_bump : overruns;
          end
          if (fire && pend_valid) begin
            res <= make_res(4'(pend_index), 1'b1, ctts_pkg::STATUS_OK, pend_fault,
                            pend_ovr, ticks, 1'b0);
          end else begin
            res.strobe <= 1'b0;
          end
          if (walk_last) begin
            state <= ST_FLUSH;
          end else begin
            walk <= walk + ctts_pkg::SLOT_W'(1);
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            res <= make_res(4'(pend_index), 1'b1, ctts_pkg::STATUS_OK, pend_fault,
                            pend_ovr, ticks, 1'b1);
          end else begin
            res <= make_res(4'd0, 1'b0, ctts_pkg::STATUS_OK, 1'b0,
                            overruns, ticks, 1'b1);
          end
          pend_valid <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          res.strobe <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cyclic_task_tick_scheduler_unit.sv
// Top level of the cyclic task tick scheduler: front queue and back end joined.
//
// Usage: drive kind, current_time and interval with start high; a word is taken at a
// rising edge where start is high and busy is low. busy rises only while the
// two-word queue between the front and the back end is full.
// Results leave on task_index, fired, status, fault_raised, overrun_count,
// tick_count and last_result, each valid for exactly one cycle while result_strobe
// is high. The receiver cannot stall; every strobed word must be taken as it passes.
// last_result marks the final word of each input word.
// Register, start and stop words, and ticks that do not walk the table, give one
// result, registered when the back end pops the word, and leave the back end idle.
// A running tick walks the used slots one per cycle through the back end's single
// table port, then releases the final firing in the flush state; it takes no new word
// until then and gives one result per fired slot, or one no-fire result.
// Synchronous reset clears the table count, time, tick and overrun counters, the
// running flag and the queue; no clearing pass is needed, as only registered slots
// are ever read.
module cyclic_task_tick_scheduler_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind,
  input  logic [31:0] current_time,
  input  logic [31:0] interval,
  output logic result_strobe,
  output logic [3:0] task_index,
  output logic fired,
  output logic [1:0] status,
  output logic fault_raised,
  output logic [30:0] overrun_count,
  output logic [31:0] tick_count,
  output logic last_result
);

  logic cmd_valid;
  logic cmd_pop;
  ctts_pkg::cmd_t cmd;
  ctts_pkg::result_t res;

  ctts_front u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .current_time(current_time),
    .interval(interval),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop)
  );

  ctts_back u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .cmd_pop(cmd_pop),
    .res(res)
  );

  assign result_strobe = res.strobe;
  assign task_index = res.task_index;
  assign fired = res.fired;
  assign status = res.status;
  assign fault_raised = res.fault_raised;
  assign overrun_count = res.overrun_count;
  assign tick_count = res.tick_count;
  assign last_result = res.last_result;

endmodule
